// ===== design/mrr_pkg.sv =====
// Shared types, codes and the CRC-16 byte fold for the register read master.
package mrr_pkg;

  // Input item codes (tuser of the input stream)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RXBYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Outcome status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Result kinds (tuser of the output stream)
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  // Protocol constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] REG_COUNT = 16'h0001;
  localparam logic [7:0] SLAVE_RESET = 8'h01;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [2:0] RESP_CRC_LO_IDX = 3'd5;
  localparam logic [2:0] RESP_CRC_HI_IDX = 3'd6;
  localparam logic [2:0] RESP_VAL_HI_IDX = 3'd3;
  localparam logic [2:0] RESP_VAL_LO_IDX = 3'd4;
  localparam logic [2:0] REQ_CRC_LO_IDX = 3'd6;
  localparam logic [2:0] REQ_LAST_IDX = 3'd7;

  // Command passed from the front end to the byte sequencer
  typedef struct packed {
    logic        outcome;   // 1: report outcome, 0: send a request
    logic [15:0] addr;      // register address for a request
    logic [15:0] reading;   // value for an outcome
    logic [1:0]  status;    // status for an outcome
  } cmd_t;

  // One byte folded into a CRC-16/Modbus value
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mrr_front.sv =====
// Front end: takes input items, tracks the reply and timeout, queues commands.
module mrr_front import mrr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_rx,
  input  logic [15:0] timeout_ticks,
  output logic        push,
  output cmd_t        push_cmd
);

  logic        waiting;
  logic [2:0]  rx_count;
  logic [15:0] running_crc;
  logic [15:0] value_bytes;
  logic [7:0]  crc_low_byte;
  logic [15:0] elapsed_ticks;

  logic [15:0] elapsed_next;
  logic [15:0] crc_got;

  assign elapsed_next = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign crc_got = {in_rx, crc_low_byte};

  // Command decode for the queue
  always_comb begin
    push = 1'b0;
    push_cmd = '0;
    if (in_valid) begin
      case (in_op)
        OP_START: begin
          push = 1'b1;
          push_cmd.outcome = 1'b0;
          push_cmd.addr = in_addr;
        end
        OP_RXBYTE: begin
          if (waiting && rx_count == RESP_CRC_HI_IDX) begin
            push = 1'b1;
            push_cmd.outcome = 1'b1;
            if (crc_got == running_crc) begin
              push_cmd.reading = value_bytes;
              push_cmd.status = STATUS_OK;
            end else begin
              push_cmd.status = STATUS_CRC_ERR;
            end
          end
        end
        OP_TICK: begin
          if (waiting && elapsed_next >= timeout_ticks) begin
            push = 1'b1;
            push_cmd.outcome = 1'b1;
            push_cmd.status = STATUS_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
  end

  // Transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= 1'b0;
      rx_count <= '0;
      running_crc <= CRC_INIT;
      value_bytes <= '0;
      crc_low_byte <= '0;
      elapsed_ticks <= '0;
    end else if (in_valid) begin
      case (in_op)
        OP_START: begin
          waiting <= 1'b1;
          rx_count <= '0;
          running_crc <= CRC_INIT;
          value_bytes <= '0;
          crc_low_byte <= '0;
          elapsed_ticks <= '0;
        end
        OP_RXBYTE: begin
          if (waiting) begin
            if (rx_count < RESP_CRC_LO_IDX) begin
              running_crc <= crc_fold(running_crc, in_rx);
              if (rx_count == RESP_VAL_HI_IDX) begin
                value_bytes[15:8] <= in_rx;
              end else if (rx_count == RESP_VAL_LO_IDX) begin
                value_bytes[7:0] <= in_rx;
              end
              rx_count <= rx_count + 3'd1;
            end else if (rx_count == RESP_CRC_LO_IDX) begin
              crc_low_byte <= in_rx;
              rx_count <= rx_count + 3'd1;
            end else begin
              waiting <= 1'b0;
              rx_count <= '0;
            end
          end
        end
        OP_TICK: begin
          if (waiting) begin
            elapsed_ticks <= elapsed_next;
            if (elapsed_next >= timeout_ticks) begin
              waiting <= 1'b0;
              rx_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/mrr_cmd_fifo.sv =====
// Two-entry command queue between the front end and the byte sequencer.
module mrr_cmd_fifo import mrr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/mrr_back.sv =====
// Byte sequencer: turns queued commands into request bytes or outcome items.
module mrr_back import mrr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [7:0]  slave_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx,
  output logic        out_last,
  output logic [15:0] out_reading,
  output logic [1:0]  out_status
);

  logic        busy;
  logic [2:0]  idx;
  logic [15:0] addr;
  logic [15:0] crc;

  logic        out_free;
  logic        start_req;
  logic [2:0]  cur_idx;
  logic [15:0] cur_addr;
  logic [15:0] cur_crc;
  logic [7:0]  cur_byte;

  assign out_free = !out_valid || out_ready;
  assign cmd_pop = !busy && out_free && cmd_valid;
  assign start_req = cmd_pop && !cmd.outcome;

  assign cur_idx = busy ? idx : 3'd0;
  assign cur_addr = busy ? addr : cmd.addr;
  assign cur_crc = busy ? crc : CRC_INIT;

  // Request byte for the current position
  always_comb begin
    case (cur_idx)
      3'd0:    cur_byte = slave_address;
      3'd1:    cur_byte = FUNC_READ_HOLDING;
      3'd2:    cur_byte = cur_addr[15:8];
      3'd3:    cur_byte = cur_addr[7:0];
      3'd4:    cur_byte = REG_COUNT[15:8];
      3'd5:    cur_byte = REG_COUNT[7:0];
      3'd6:    cur_byte = cur_crc[7:0];
      default: cur_byte = cur_crc[15:8];
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else if (out_free) begin
      if (busy || start_req) begin
        out_valid <= 1'b1;
        out_kind <= KIND_TX;
        out_tx <= cur_byte;
        out_last <= (cur_idx == REQ_LAST_IDX);
        out_reading <= '0;
        out_status <= STATUS_OK;
        addr <= cur_addr;
        if (cur_idx < REQ_CRC_LO_IDX) begin
          crc <= crc_fold(cur_crc, cur_byte);
        end
        idx <= cur_idx + 3'd1;
        busy <= (cur_idx != REQ_LAST_IDX);
      end else if (cmd_pop) begin
        out_valid <= 1'b1;
        out_kind <= KIND_OUTCOME;
        out_tx <= '0;
        out_last <= 1'b0;
        out_reading <= cmd.reading;
        out_status <= cmd.status;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/modbus_read_register_master_unit.sv =====
// Top level of the Modbus RTU single holding register read master.
// An input item is taken whenever the two-entry command queue has room. While
// the queue is full, every input item waits, including bytes and ticks that
// produce no result, until the byte sequencer pops a command. A start item
// yields eight request bytes, one per cycle from the byte sequencer while the
// output is not stalled. An outcome is a single output item. A stalled output
// holds the sequencer, and that stall reaches the input once the queue fills.
// The CRC of the request is folded one byte per cycle in the sequencer while
// the output is not stalled. The reply CRC is folded one byte per received item
// in the front end. Configuration writes take effect on the next cycle and are
// meant to be made while no transaction output is pending.
module modbus_read_register_master_unit import mrr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // register_address[15:0], rx_data[23:16]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // tx_data[7:0], reading[23:8], status[25:24], zero
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  slave_address;
  logic [15:0] timeout_ticks;

  logic        fifo_full;
  logic        in_fire;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  logic        not_empty;
  cmd_t        head;
  logic [7:0]  out_tx;
  logic [15:0] out_reading;
  logic [1:0]  out_status;

  assign s_axis_tready = !fifo_full;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {6'd0, out_status, out_reading, out_tx};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mrr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_fire),
    .in_op         (s_axis_tuser),
    .in_addr       (s_axis_tdata[15:0]),
    .in_rx         (s_axis_tdata[23:16]),
    .timeout_ticks (timeout_ticks),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  mrr_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mrr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (not_empty),
    .cmd           (head),
    .cmd_pop       (pop),
    .slave_address (slave_address),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_kind      (m_axis_tuser),
    .out_tx        (out_tx),
    .out_last      (m_axis_tlast),
    .out_reading   (out_reading),
    .out_status    (out_status)
  );

endmodule

// ===== design/mrr_checker.sv =====
// Port-level checks for the register read master, bound to the top level.
module mrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Output valid and data hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // Only request bytes end a run
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("tlast on an outcome item");

  // Request bytes carry no reading or status
  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:8] == 24'd0)
    else $error("request byte with reading or status bits");

  // Outcomes carry no tx byte and a defined status
  a_outcome_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0 &&
      m_axis_tdata[25:24] != 2'd3)
    else $error("malformed outcome item");

  // Nothing presented right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind modbus_read_register_master_unit mrr_checker u_mrr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb.sv =====
// Self-checking stream testbench for the Modbus RTU holding register read master.
`timescale 1ns / 100ps

module tb;
  import mrr_pkg::*;

  // Stimulus-side codes and frame constants
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [15:0] MODBUS_POLY = 16'hA001;
  localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
  localparam logic [7:0]  READ_FUNC = 8'h03;
  localparam logic [7:0]  REPLY_BYTE_COUNT = 8'h02;
  localparam int          REQ_LEN = 8;
  localparam int          REQ_BODY_LEN = 6;
  localparam int          REPLY_LEN = 7;
  localparam int          REPLY_CRC_SPAN = 5;
  localparam int          VALUE_HI_POS = 3;
  localparam int          VALUE_LO_POS = 4;
  localparam int          CRC_LO_POS = 5;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          WAIT_LIMIT = 200000;
  localparam int          PRINT_LIMIT = 25;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  rx;
  } bus_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [15:0] reading;
    logic [1:0]  status;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // register_address[15:0], rx_data[23:16]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // tx_data[7:0], reading[23:8], status[25:24], zero
  logic        m_axis_tuser;        // kind
  logic        m_axis_tlast;        // last
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Pacing and bookkeeping
  int send_idle_pct = 6;
  int recv_idle_pct = 70;
  int errors = 0;
  int items_queued = 0;
  int items_taken = 0;
  int requests_seen = 0;
  int outcomes_ok = 0;
  int outcomes_crc = 0;
  int outcomes_timeout = 0;
  logic in_taken = 1'b0;

  bus_item_t     pending_q[$];
  frame_result_t expected_q[$];
  bus_item_t     drive_item;
  frame_result_t got_result;
  frame_result_t want_result;

  // Predictor copy of the registers and transaction state
  logic [7:0]  pred_slave = 8'h01;
  logic [15:0] pred_timeout = 16'd1000;
  logic        link_waiting = 1'b0;
  logic [2:0]  reply_count = '0;
  logic [15:0] reply_crc = MODBUS_SEED;
  logic [15:0] reply_value = '0;
  logic [7:0]  reply_crc_lo = '0;
  logic [15:0] tick_count = '0;

  modbus_read_register_master_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // CRC-16/Modbus, one byte, LSB first
  function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) begin
      acc = acc[0] ? ({1'b0, acc[15:1]} ^ MODBUS_POLY) : {1'b0, acc[15:1]};
    end
    return acc;
  endfunction

  // Expected results of one accepted item; updates the transaction state
  function automatic void predict_item(bus_item_t it);
    logic [7:0]    req [REQ_LEN];
    logic [15:0]   crc;
    frame_result_t r;
    int            i;
    r = '0;
    if (it.op == OP_START) begin
      req[0] = pred_slave;
      req[1] = READ_FUNC;
      req[2] = it.addr[15:8];
      req[3] = it.addr[7:0];
      req[4] = 8'h00;
      req[5] = 8'h01;
      crc = MODBUS_SEED;
      for (i = 0; i < REQ_BODY_LEN; i++) crc = modbus_crc_byte(crc, req[i]);
      req[6] = crc[7:0];
      req[7] = crc[15:8];
      for (i = 0; i < REQ_LEN; i++) begin
        r.kind = KIND_TX;
        r.tx = req[i];
        r.last = (i == REQ_LEN - 1);
        expected_q.push_back(r);
      end
      // a start always drops whatever exchange was open
      link_waiting = 1'b1;
      reply_count = '0;
      reply_crc = MODBUS_SEED;
      reply_value = '0;
      reply_crc_lo = '0;
      tick_count = '0;
      requests_seen++;
    end else if (link_waiting && it.op == OP_RXBYTE) begin
      if (reply_count < REPLY_CRC_SPAN) begin
        reply_crc = modbus_crc_byte(reply_crc, it.rx);
        if (reply_count == VALUE_HI_POS) reply_value[15:8] = it.rx;
        else if (reply_count == VALUE_LO_POS) reply_value[7:0] = it.rx;
        reply_count++;
      end else if (reply_count == CRC_LO_POS) begin
        reply_crc_lo = it.rx;
        reply_count++;
      end else begin
        link_waiting = 1'b0;
        reply_count = '0;
        r.kind = KIND_OUTCOME;
        if ({it.rx, reply_crc_lo} == reply_crc) begin
          r.reading = reply_value;
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_CRC_ERR;
        end
        expected_q.push_back(r);
      end
    end else if (link_waiting && it.op == OP_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count >= pred_timeout) begin
        link_waiting = 1'b0;
        reply_count = '0;
        r.kind = KIND_OUTCOME;
        r.status = STATUS_TIMEOUT;
        expected_q.push_back(r);
      end
    end
  endfunction

  // Item for the driver; the field the op does not use gets random bits
  task automatic queue_item(logic [1:0] op, logic [15:0] value);
    bus_item_t it;
    it.op = op;
    it.addr = 16'($urandom);
    it.rx = 8'($urandom);
    if (op == OP_START) it.addr = value;
    else if (op == OP_RXBYTE) it.rx = value[7:0];
    pending_q.push_back(it);
    items_queued++;
  endtask

  // Slave reply: address, function, count, value, CRC; optionally cut short or
  // hit by a bit error, with ticks sprinkled in between the bytes
  task automatic queue_reply(logic [7:0] first_byte, logic [15:0] value, int n_bytes,
                             int corrupt_at, int tick_pct);
    logic [7:0]  b [REPLY_LEN];
    logic [15:0] crc;
    int          i;
    b[0] = first_byte;
    b[1] = READ_FUNC;
    b[2] = REPLY_BYTE_COUNT;
    b[3] = value[15:8];
    b[4] = value[7:0];
    crc = MODBUS_SEED;
    for (i = 0; i < REPLY_CRC_SPAN; i++) crc = modbus_crc_byte(crc, b[i]);
    b[5] = crc[7:0];
    b[6] = crc[15:8];
    if (corrupt_at >= 0) b[corrupt_at] = b[corrupt_at] ^ (8'h01 << $urandom_range(7));
    for (i = 0; i < n_bytes; i++) begin
      while ($urandom_range(99) < tick_pct) queue_item(OP_TICK, 16'($urandom));
      queue_item(OP_RXBYTE, {8'h00, b[i]});
    end
  endtask

  // Mostly complete exchanges, plus cut-short ones, tick runs and noise
  task automatic queue_random_traffic(int target);
    int          first_item;
    int          pick;
    int          corrupt_at;
    int          n;
    int          i;
    logic [15:0] value;
    logic [7:0]  first_byte;
    first_item = items_queued;
    while (items_queued - first_item < target) begin
      pick = $urandom_range(99);
      value = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                       : 16'($urandom);
      first_byte = ($urandom_range(3) == 0) ? 8'($urandom) : pred_slave;
      if (pick < 65) begin
        corrupt_at = ($urandom_range(99) < 20) ? int'($urandom_range(REPLY_LEN - 1)) : -1;
        queue_item(OP_START, 16'($urandom));
        queue_reply(first_byte, value, REPLY_LEN, corrupt_at, 25);
        // stray bytes after the outcome fall into idle
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) queue_item(OP_RXBYTE, 16'($urandom));
        end
      end else if (pick < 75) begin
        n = $urandom_range(REPLY_LEN - 1);
        queue_item(OP_START, 16'($urandom));
        queue_reply(first_byte, value, n, -1, 25);
      end else if (pick < 88) begin
        n = $urandom_range(1, 15);
        queue_item(OP_START, 16'($urandom));
        for (i = 0; i < n; i++) queue_item(OP_TICK, 16'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) queue_item(2'($urandom), 16'($urandom));
      end
    end
  endtask

  // Register write at the falling edge; the predictor follows at once
  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_SLAVE_ADDRESS) pred_slave = value[7:0];
    else pred_timeout = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic settle();
    int waited;
    waited = 0;
    while ((pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
           && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver and receiver backpressure, both at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!s_axis_tvalid || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= drive_item.op;
          s_axis_tdata <= {drive_item.rx, drive_item.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Input monitor: every accepted item goes through the predictor
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(bus_item_t'({s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]}));
        items_taken++;
      end
    end
  end

  // Output monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.kind = m_axis_tuser;
      got_result.tx = m_axis_tdata[7:0];
      got_result.last = m_axis_tlast;
      got_result.reading = m_axis_tdata[23:8];
      got_result.status = m_axis_tdata[25:24];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_LIMIT)
          $display("%0t: unexpected result, expected none, actual kind=%0d tdata=%08h last=%0d",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want_result = expected_q.pop_front();
        if (got_result !== want_result || m_axis_tdata[31:26] !== 6'd0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display({"%0t: expected kind=%0d tx=%02h last=%0d reading=%04h status=%0d,",
                      " actual kind=%0d tx=%02h last=%0d reading=%04h status=%0d pad=%02h"},
                     $time, want_result.kind, want_result.tx, want_result.last,
                     want_result.reading, want_result.status, got_result.kind,
                     got_result.tx, got_result.last, got_result.reading,
                     got_result.status, m_axis_tdata[31:26]);
        end
        if (want_result.kind == KIND_OUTCOME) begin
          case (want_result.status)
            STATUS_OK: outcomes_ok++;
            STATUS_CRC_ERR: outcomes_crc++;
            default: outcomes_timeout++;
          endcase
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(4_000_000);
    $display("%0t: run timed out with %0d items pending and %0d results outstanding",
             $time, pending_q.size(), expected_q.size());
    $display("modbus_read_register_master_unit: mismatch");
    $finish;
  end

  // Test sequence
  initial begin
    int          seg;
    logic [7:0]  slave;
    logic [15:0] tmo;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (seg = 0; seg < 6; seg++) begin
      if (seg == 0) begin
        // directed: reset register values, idle traffic, good and bad replies, restart
        queue_item(OP_TICK, 16'h0000);
        queue_item(OP_RXBYTE, 16'h00FF);
        queue_item(OP_START, 16'h0000);
        queue_reply(8'h01, 16'hFFFF, REPLY_LEN, -1, 0);
        queue_item(OP_START, 16'hFFFF);
        queue_item(OP_UNUSED, 16'h0000);
        queue_reply(8'h01, 16'h1234, REPLY_LEN, REPLY_LEN - 1, 0);
        queue_item(OP_RXBYTE, 16'h00AA);
        queue_item(OP_START, 16'h5AA5);
        queue_reply(8'h01, 16'h0000, 1, -1, 0);
        queue_item(OP_START, 16'h00FF);
        queue_reply(8'h01, 16'h0000, REPLY_LEN, -1, 0);
      end else begin
        settle();
        case (seg)
          1: begin slave = 8'h00; tmo = 16'd0; end
          2: begin slave = 8'hFF; tmo = 16'd1; end
          3: begin slave = 8'($urandom); tmo = 16'($urandom_range(3, 12)); end
          4: begin slave = 8'($urandom); tmo = 16'($urandom_range(2, 20)); end
          default: begin slave = 8'($urandom); tmo = 16'hFFFF; end
        endcase
        // upper data bits are don't-care for the slave address register
        write_reg(CFG_SLAVE_ADDRESS, {8'($urandom), slave});
        write_reg(CFG_TIMEOUT_TICKS, tmo);
      end
      send_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 70 : 0;
      recv_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 6 : 0;
      queue_random_traffic((seg == 0) ? 50 : 75);
    end

    settle();
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_q.size());
    end
    $display("Covered %0d input items and %0d request frames over six register settings",
             items_taken, requests_seen);
    $display("Outcomes seen: %0d ok, %0d CRC error, %0d timeout; %0d failures",
             outcomes_ok, outcomes_crc, outcomes_timeout, errors);
    if (errors == 0) begin
      $display("modbus_read_register_master_unit: match");
    end else begin
      $display("modbus_read_register_master_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mrr_pkg.sv
design/mrr_front.sv
design/mrr_cmd_fifo.sv
design/mrr_back.sv
design/modbus_read_register_master_unit.sv
design/mrr_checker.sv
sim/tb.sv
